FILE: rtl/core/card_number_luhn_classifier_assert.svh
// Assertion macros shared by the card number classifier RTL.
// Each macro expects clk and arst_n in the scope of its use.
`ifndef CARD_NUMBER_LUHN_CLASSIFIER_ASSERT_SVH
`define CARD_NUMBER_LUHN_CLASSIFIER_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define CNLC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define CNLC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: rtl/core/cnlc_pkg.sv
package cnlc_pkg;

	// Input width and number of decimal cells (2^63 has 19 digits)
	localparam int CARD_W     = 63;
	localparam int NUM_DIGITS = 19;
	localparam int DIG_IDX_W  = 5;
	localparam int BIT_IDX_W  = 6;

	// Length and prefix constants of the brand rules
	localparam logic [4:0] LEN_13 = 5'd13;
	localparam logic [4:0] LEN_15 = 5'd15;
	localparam logic [4:0] LEN_16 = 5'd16;
	localparam logic [3:0] DIG_3  = 4'd3;
	localparam logic [3:0] DIG_4  = 4'd4;
	localparam logic [3:0] DIG_5  = 4'd5;
	localparam logic [3:0] DIG_1  = 4'd1;
	localparam logic [3:0] DIG_7  = 4'd7;

	// Brand codes
	localparam logic [1:0] BRAND_NONE   = 2'd0;
	localparam logic [1:0] BRAND_FIRST  = 2'd1;
	localparam logic [1:0] BRAND_SECOND = 2'd2;
	localparam logic [1:0] BRAND_THIRD  = 2'd3;

	// Control handed from the sequencer to the cell row and accumulator
	typedef struct packed {
		logic clr;
		logic shift_bit;
		logic shift_digit;
	} ctl_t;

endpackage

FILE: rtl/core/cnlc_cell.sv
module cnlc_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  cnlc_pkg::ctl_t  ctl,
	input  logic            bit_in,
	input  logic [3:0]      digit_in,
	output logic            bit_out,
	output logic [3:0]      digit
);

	logic [3:0] digit_q;
	logic [3:0] adj;

	// Add three to a digit of five or more before the shift
	assign adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign bit_out = adj[3];
	assign digit   = digit_q;

	// Clear, shift one binary bit in, or take the neighbor's digit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= 4'd0;
		end else if (ctl.clr) begin
			digit_q <= 4'd0;
		end else if (ctl.shift_bit) begin
			digit_q <= {adj[2:0], bit_in};
		end else if (ctl.shift_digit) begin
			digit_q <= digit_in;
		end
	end

endmodule

FILE: rtl/core/cnlc_digit_acc.sv
module cnlc_digit_acc (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cnlc_pkg::ctl_t                  ctl,
	input  logic [3:0]                      digit,
	input  logic [cnlc_pkg::DIG_IDX_W-1:0]  pos,
	output logic [3:0]                      sum,
	output logic [cnlc_pkg::DIG_IDX_W-1:0]  count,
	output logic [3:0]                      lead,
	output logic [3:0]                      next_dig
);

	logic [3:0] sum_q;
	logic [cnlc_pkg::DIG_IDX_W-1:0] count_q;
	logic [3:0] lead_q;
	logic [3:0] next_q;
	logic [3:0] prev_q;
	logic [4:0] dbl;
	logic [3:0] w;
	logic [4:0] s;

	// Weight the digit: double odd positions, fold values above nine
	always_comb begin
		dbl = {digit, 1'b0};
		if (pos[0]) begin
			w = (dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[3:0];
		end else begin
			w = digit;
		end
		s = {1'b0, sum_q} + {1'b0, w};
	end

	// Keep the sum mod ten, the length and the two leading digits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= 4'd0;
			count_q <= cnlc_pkg::DIG_IDX_W'(1);
			lead_q  <= 4'd0;
			next_q  <= 4'd0;
			prev_q  <= 4'd0;
		end else if (ctl.clr) begin
			sum_q   <= 4'd0;
			count_q <= cnlc_pkg::DIG_IDX_W'(1);
			lead_q  <= 4'd0;
			next_q  <= 4'd0;
			prev_q  <= 4'd0;
		end else if (ctl.shift_digit) begin
			sum_q  <= (s >= 5'd10) ? 4'(s - 5'd10) : s[3:0];
			prev_q <= digit;
			if (digit != 4'd0) begin
				count_q <= pos + cnlc_pkg::DIG_IDX_W'(1);
				lead_q  <= digit;
				next_q  <= prev_q;
			end
		end
	end

	assign sum      = sum_q;
	assign count    = count_q;
	assign lead     = lead_q;
	assign next_dig = next_q;

endmodule

FILE: rtl/core/card_number_luhn_classifier.sv
// Channel  Handshake            Payload
// -------  -------------------  ------------------------------------
// in       in_valid / in_stall  card_number[62:0]
// out      out_valid/ out_stall brand_code[1:0], luhn_ok, digit_count[4:0]
//
// Each item passes through accept, binary-to-decimal shifting of its 63 bits
// through the row of 19 digit cells, draining of the digits into the
// Luhn accumulator, and a classify step into the output register.
// The next item is accepted once the previous one sits in the output register.
// Reset (arst_n low) returns the sequencer to idle and empties the output.
// A stalled output holds the finished item in the classify step.
`include "card_number_luhn_classifier_assert.svh"

module card_number_luhn_classifier (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [cnlc_pkg::CARD_W-1:0]   card_number,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    brand_code,
	output logic                          luhn_ok,
	output logic [4:0]                    digit_count
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CONV  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	localparam int N = cnlc_pkg::NUM_DIGITS;

	state_t state_q;
	logic [cnlc_pkg::CARD_W-1:0]    card_q;
	logic [cnlc_pkg::BIT_IDX_W-1:0] bit_cnt_q;
	logic [cnlc_pkg::DIG_IDX_W-1:0] dig_cnt_q;
	logic out_valid_q;
	logic [1:0] brand_q;
	logic luhn_q;
	logic [4:0] count_out_q;

	cnlc_pkg::ctl_t ctl;
	logic accept;
	logic load_out;
	logic [N-1:0] bit_chain;
	logic [3:0] digits [N];
	logic [3:0] sum;
	logic [cnlc_pkg::DIG_IDX_W-1:0] count;
	logic [3:0] lead;
	logic [3:0] next_dig;
	logic ok;
	logic [1:0] brand;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign load_out = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	// Drive the cell row and accumulator from the sequencer state
	always_comb begin
		ctl.clr         = accept;
		ctl.shift_bit   = (state_q == ST_CONV);
		ctl.shift_digit = (state_q == ST_DRAIN);
	end

	// Row of decimal cells; binary bits enter at cell 0, digits drain to cell 0
	assign bit_chain[0] = card_q[cnlc_pkg::CARD_W-1];
	for (genvar i = 0; i < N; i++) begin : g_cell
		if (i < N - 1) begin : g_mid
			cnlc_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.bit_in   (bit_chain[i]),
				.digit_in (digits[i+1]),
				.bit_out  (bit_chain[i+1]),
				.digit    (digits[i])
			);
		end else begin : g_last
			cnlc_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.bit_in   (bit_chain[i]),
				.digit_in (4'd0),
				.bit_out  (),
				.digit    (digits[i])
			);
		end
	end

	cnlc_digit_acc u_acc (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.digit    (digits[0]),
		.pos      (dig_cnt_q),
		.sum      (sum),
		.count    (count),
		.lead     (lead),
		.next_dig (next_dig)
	);

	// Classify by Luhn result, length and leading pair
	always_comb begin
		ok    = (sum == 4'd0);
		brand = cnlc_pkg::BRAND_NONE;
		if (ok) begin
			if (count == cnlc_pkg::LEN_13 ||
			    (count == cnlc_pkg::LEN_16 && lead == cnlc_pkg::DIG_4)) begin
				brand = cnlc_pkg::BRAND_FIRST;
			end else if (count == cnlc_pkg::LEN_15 && lead == cnlc_pkg::DIG_3 &&
			             (next_dig == cnlc_pkg::DIG_4 || next_dig == cnlc_pkg::DIG_7)) begin
				brand = cnlc_pkg::BRAND_SECOND;
			end else if (count == cnlc_pkg::LEN_16 && lead == cnlc_pkg::DIG_5 &&
			             (next_dig == cnlc_pkg::DIG_1 || next_dig == cnlc_pkg::DIG_5)) begin
				brand = cnlc_pkg::BRAND_THIRD;
			end
		end
	end

	// Sequence: convert, drain, classify
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q   <= ST_CONV;
						bit_cnt_q <= '0;
					end
				end
				ST_CONV: begin
					if (bit_cnt_q == cnlc_pkg::BIT_IDX_W'(cnlc_pkg::CARD_W - 1)) begin
						state_q   <= ST_DRAIN;
						dig_cnt_q <= '0;
					end else begin
						bit_cnt_q <= bit_cnt_q + cnlc_pkg::BIT_IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					if (dig_cnt_q == cnlc_pkg::DIG_IDX_W'(N - 1)) begin
						state_q <= ST_FIN;
					end else begin
						dig_cnt_q <= dig_cnt_q + cnlc_pkg::DIG_IDX_W'(1);
					end
				end
				ST_FIN: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Load the number on accept, shift it out MSB first while converting
	always_ff @(posedge clk) begin
		if (accept) begin
			card_q <= card_number;
		end else if (state_q == ST_CONV) begin
			card_q <= {card_q[cnlc_pkg::CARD_W-2:0], 1'b0};
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			brand_q     <= brand;
			luhn_q      <= ok;
			count_out_q <= count;
		end
	end

	assign out_valid   = out_valid_q;
	assign brand_code  = brand_q;
	assign luhn_ok     = luhn_q;
	assign digit_count = count_out_q;

	`CNLC_ASSERT_NEXT(a_conv_to_drain,
		state_q == ST_CONV && bit_cnt_q == cnlc_pkg::BIT_IDX_W'(cnlc_pkg::CARD_W - 1),
		state_q == ST_DRAIN)
	`CNLC_ASSERT_NEXT(a_load_sets_valid, load_out, out_valid_q && state_q == ST_IDLE)
	`CNLC_ASSERT_SAME(a_count_range, out_valid_q,
		digit_count != 5'd0 && digit_count <= 5'(N))
	`CNLC_ASSERT_SAME(a_brand_needs_luhn, out_valid_q && brand_code != cnlc_pkg::BRAND_NONE,
		luhn_ok)

endmodule

FILE: tb/tb_card_number_luhn_classifier.sv
`timescale 1ns / 1ps

module tb_card_number_luhn_classifier;

	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int DRAIN_CYCLES = 200;
	localparam int HOLD_CYCLES  = 700;
	localparam int MAX_REPORTS  = 60;

	typedef struct {
		logic [cnlc_pkg::CARD_W-1:0] card;
		logic [1:0]                  brand;
		logic                        ok;
		logic [4:0]                  count;
	} card_verdict_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [cnlc_pkg::CARD_W-1:0] card_number = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [1:0]                  brand_code;
	logic                        luhn_ok;
	logic [4:0]                  digit_count;

	card_verdict_t pending_verdicts[$];
	int            mismatches = 0;
	int            cycle_count = 0;
	int            send_idle_pct = 0;
	int            stall_pct = 0;
	logic          holding = 1'b0;

	card_number_luhn_classifier dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.card_number(card_number),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.brand_code (brand_code),
		.luhn_ok    (luhn_ok),
		.digit_count(digit_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Walk the decimal digits from the right: Luhn sum, length, two leading digits
	function automatic void scan_digits(input logic [cnlc_pkg::CARD_W-1:0] num,
			output int unsigned sum, output int unsigned count,
			output logic [3:0] lead, output logic [3:0] second);
		logic [cnlc_pkg::CARD_W-1:0] v;
		logic [3:0]                  d;
		int unsigned                 w;
		v = num;
		sum = 0;
		count = 0;
		lead = '0;
		second = '0;
		do begin
			d = 4'(v % 10);
			v = v / 10;
			w = d;
			if (count % 2 == 1) begin
				w = d * 2;
				if (w > 9)
					w = w - 9;
			end
			sum += w;
			second = lead;
			lead = d;
			count++;
		end while (v != 0);
	endfunction

	function automatic card_verdict_t classify_card(input logic [cnlc_pkg::CARD_W-1:0] num);
		card_verdict_t vd;
		int unsigned   sum, count;
		logic [3:0]    lead, second;
		logic [4:0]    len;
		scan_digits(num, sum, count, lead, second);
		len = 5'(count);
		vd.card = num;
		vd.count = len;
		vd.ok = (sum % 10 == 0);
		vd.brand = cnlc_pkg::BRAND_NONE;
		if (vd.ok) begin
			if (len == cnlc_pkg::LEN_13 ||
			    (len == cnlc_pkg::LEN_16 && lead == cnlc_pkg::DIG_4))
				vd.brand = cnlc_pkg::BRAND_FIRST;
			else if (len == cnlc_pkg::LEN_15 && lead == cnlc_pkg::DIG_3 &&
			         (second == cnlc_pkg::DIG_4 || second == cnlc_pkg::DIG_7))
				vd.brand = cnlc_pkg::BRAND_SECOND;
			else if (len == cnlc_pkg::LEN_16 && lead == cnlc_pkg::DIG_5 &&
			         (second == cnlc_pkg::DIG_1 || second == cnlc_pkg::DIG_5))
				vd.brand = cnlc_pkg::BRAND_THIRD;
		end
		return vd;
	endfunction

	// Build a number of len digits behind a prefix, with a good or a broken check digit
	function automatic logic [cnlc_pkg::CARD_W-1:0] make_card(input int unsigned prefix,
			input int unsigned prefix_len, input int unsigned len, input bit luhn_good);
		logic [cnlc_pkg::CARD_W-1:0] num;
		int unsigned                 sum, count;
		logic [3:0]                  lead, second;
		int unsigned                 chk;
		num = cnlc_pkg::CARD_W'(prefix);
		for (int unsigned i = prefix_len; i + 1 < len; i++)
			num = num * 10 + cnlc_pkg::CARD_W'($urandom_range(9));
		num = num * 10;
		scan_digits(num, sum, count, lead, second);
		chk = (10 - sum % 10) % 10;
		if (!luhn_good)
			chk = (chk + 1 + $urandom_range(8)) % 10;
		return num + cnlc_pkg::CARD_W'(chk);
	endfunction

	task automatic report_mismatch(input string what,
			input logic [cnlc_pkg::CARD_W-1:0] card, input int got, input int want);
		if (mismatches < MAX_REPORTS)
			$display("MISMATCH %s card=%0d got=%0d want=%0d", what, card, got, want);
		mismatches++;
	endtask

	// Record the expected verdict of every accepted item
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			pending_verdicts.push_back(classify_card(card_number));
	end

	// Compare each accepted result with the oldest expected verdict
	always @(posedge clk) begin
		card_verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				report_mismatch("unexpected result, brand", '0, brand_code, 0);
			end else begin
				want = pending_verdicts.pop_front();
				if (brand_code !== want.brand)
					report_mismatch("brand_code", want.card, brand_code, want.brand);
				if (luhn_ok !== want.ok)
					report_mismatch("luhn_ok", want.card, luhn_ok, want.ok);
				if (digit_count !== want.count)
					report_mismatch("digit_count", want.card, digit_count, want.count);
			end
		end
	end

	// Stall the output at random, or hold it for a long stretch
	always @(negedge clk) begin
		out_stall <= holding || ($urandom_range(99) < stall_pct);
	end

	// Give up on a hung run
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** card_number_luhn_classifier: FAILED **");
		$finish;
	end

	// Offer one item after a random gap; return at the accepting edge
	task automatic send_card(input logic [cnlc_pkg::CARD_W-1:0] num);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		card_number <= num;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	task automatic release_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drain();
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_extremes();
		send_card('0);
		send_card({cnlc_pkg::CARD_W{1'b1}});
		send_card(63'd1);
		send_card(63'd9);
		send_card(63'd59);
		send_card(63'd1_000_000_000_000_000_000);
		send_card(63'd999_999_999_999_999_999);
		send_card(63'd4_111_111_111_111_111);
		send_card({32'hAAAA_AAAA, 31'h2AAA_AAAA});
		send_card({32'h5555_5555, 31'h5555_5555});
		release_input();
	endtask

	task automatic test_brand_rules();
		send_card(make_card($urandom_range(1, 9), 1, 13, 1'b1));
		send_card(make_card($urandom_range(1, 9), 1, 13, 1'b0));
		send_card(make_card(4, 1, 16, 1'b1));
		send_card(make_card(4, 1, 16, 1'b0));
		send_card(make_card(34, 2, 15, 1'b1));
		send_card(make_card(37, 2, 15, 1'b1));
		send_card(make_card(37, 2, 15, 1'b0));
		send_card(make_card(38, 2, 15, 1'b1));
		send_card(make_card(51, 2, 16, 1'b1));
		send_card(make_card(55, 2, 16, 1'b1));
		send_card(make_card(55, 2, 16, 1'b0));
		send_card(make_card(52, 2, 16, 1'b1));
		send_card(make_card(56, 2, 16, 1'b1));
		send_card(make_card(4, 1, 14, 1'b1));
		send_card(make_card(4, 1, 15, 1'b1));
		release_input();
	endtask

	// Numbers of the brand lengths for half the items, other lengths or noise for the rest
	task automatic test_random(input int n, input int send_pct, input int recv_pct);
		logic [cnlc_pkg::CARD_W-1:0] num;
		bit                          good;
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
		repeat (n) begin
			good = ($urandom_range(99) < 75);
			case ($urandom_range(9))
				0: num = make_card($urandom_range(1, 9), 1, 13, good);
				1: num = make_card(4, 1, 16, good);
				2: num = make_card($urandom_range(1) ? 34 : 37, 2, 15, good);
				3: num = make_card($urandom_range(1) ? 51 : 55, 2, 16, good);
				4: num = make_card($urandom_range(10, 99), 2, $urandom_range(15, 16), good);
				5: num = make_card($urandom_range(1, 9), 1, $urandom_range(2, 18), good);
				6: num = {1'b1, 30'($urandom), 32'($urandom)};
				7, 8: num = 63'({$urandom, $urandom});
				default: num = 63'($urandom_range(999));
			endcase
			send_card(num);
		end
		release_input();
	endtask

	// Hold the output off long enough that the block stalls its input
	task automatic test_output_hold();
		send_idle_pct = 0;
		stall_pct = 0;
		fork
			begin
				@(posedge clk);
				holding = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				holding = 1'b0;
			end
			begin
				repeat (8) send_card(make_card(4, 1, 16, 1'b1));
				release_input();
			end
		join
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		test_extremes();
		test_brand_rules();
		test_output_hold();
		test_random(275, 0, 0);
		test_random(275, 58, 0);
		test_random(275, 0, 58);
		test_random(275, 9, 9);
		stall_pct = 0;
		wait_drain();
		if (mismatches == 0)
			$display("** card_number_luhn_classifier: PASSED **");
		else
			$display("** card_number_luhn_classifier: FAILED **");
		$finish;
	end

endmodule
